/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication: when cond holds, prop holds in the same cycle.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Implication: when cond holds, prop holds in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/wshp_pkg.sv */
// ----------------------------------------------------------------------------
// wshp_pkg
// Shared types and constants of the WebSocket frame header parser.
// ----------------------------------------------------------------------------
package wshp_pkg;

  localparam int unsigned ByteW = 8;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] BASE_HDR_BYTES = 4'd2;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_EXT16 = 2'd1,
    FORM_EXT64 = 2'd2
  } len_form_t;

  // registered input byte handed to the parser
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
  } beat_t;

  // one decoded header
  typedef struct packed {
    logic        fin;
    logic        rsv1;
    logic        rsv2;
    logic        rsv3;
    logic [3:0]  opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [31:0] mask_key;
    logic [3:0]  header_length;
  } hdr_t;

endpackage

/* hw/rtl/websocket_header_parser_top.sv */
// ----------------------------------------------------------------------------
// websocket_header_parser_top
// WebSocket frame header parser: one header byte in per transaction, one
// decoded header out once the last header byte has been taken.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with in_data_byte, header bytes in wire
// order. Byte 0 and byte 1 are always present, then 0, 2 or 8 extended
// length bytes (big-endian), then 4 masking key bytes when the mask bit is
// set. The next header starts with the byte after the last one.
// Output channel: out_valid / out_stall with every decoded field; mask_key
// holds the first key byte in bits 7:0 and reads zero without a mask.
// Throughput: one byte per cycle while the result register is empty or not
// stalled, set by the combinational field assembly between the input
// register and the result register. out_valid rises once the last header
// byte has passed the input register and then the result register.
// A stalled result holds; while the result register is full and stalled the
// parser takes no byte, so the input register fills and in_stall rises
// until the result is taken.
// Reset (rst_n low, synchronous) empties both registers and expects byte 0.
// ----------------------------------------------------------------------------
module websocket_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_fin,
  output logic        out_rsv1,
  output logic        out_rsv2,
  output logic        out_rsv3,
  output logic [3:0]  out_opcode,
  output logic        out_mask_present,
  output logic [63:0] out_payload_length,
  output logic [31:0] out_mask_key,
  output logic [3:0]  out_header_length
);
  import wshp_pkg::*;

  beat_t beat;
  logic  take;
  hdr_t  hdr;

  wshp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .take         (take),
    .beat         (beat)
  );

  wshp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .take      (take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_hdr   (hdr)
  );

  assign out_fin            = hdr.fin;
  assign out_rsv1           = hdr.rsv1;
  assign out_rsv2           = hdr.rsv2;
  assign out_rsv3           = hdr.rsv3;
  assign out_opcode         = hdr.opcode;
  assign out_mask_present   = hdr.mask_present;
  assign out_payload_length = hdr.payload_length;
  assign out_mask_key       = hdr.mask_key;
  assign out_header_length  = hdr.header_length;

endmodule

/* hw/rtl/wshp_in_reg.sv */
// ----------------------------------------------------------------------------
// wshp_in_reg
// Input register: captures one header byte per transaction and holds it
// until the parser takes it.
// ----------------------------------------------------------------------------
module wshp_in_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   take,
  output wshp_pkg::beat_t        beat
);
  import wshp_pkg::*;

  logic             vld_r;
  logic             vld_nxt;
  logic [ByteW-1:0] data_r;

  // full and not being taken this cycle
  assign in_stall = vld_r && !take;

  assign vld_nxt = in_stall ? vld_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data_byte;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule

/* hw/rtl/wshp_parse.sv */
// ----------------------------------------------------------------------------
// wshp_parse
// Header field assembly and result register. Consumes one registered byte
// per cycle while the result register is free; loads it as a header ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wshp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  wshp_pkg::beat_t   beat,
  output logic              take,
  input  logic              out_stall,
  output logic              out_valid,
  output wshp_pkg::hdr_t    out_hdr
);
  import wshp_pkg::*;

  logic [3:0]  pos_r,  pos_nxt;
  len_form_t   form_r, form_nxt;
  logic        mask_r, mask_nxt;
  logic [7:0]  b0_r,   b0_nxt;
  logic [63:0] len_r,  len_nxt;
  logic [31:0] key_r,  key_nxt;

  logic        res_vld_r, res_vld_nxt;
  hdr_t        res_r,     res_nxt;

  logic        out_free;
  logic        done;
  logic [3:0]  ext_cur;
  logic [3:0]  ext_nxt;
  logic [3:0]  total;
  logic [3:0]  key_idx;
  logic [6:0]  code;

  assign out_free = !res_vld_r || !out_stall;
  assign take     = beat.vld && out_free;
  assign code     = beat.data[6:0];

  always_comb begin
    case (form_r)
      FORM_EXT16: ext_cur = EXT16_BYTES;
      FORM_EXT64: ext_cur = EXT64_BYTES;
      default:    ext_cur = 4'd0;
    endcase
  end

  assign key_idx = pos_r - BASE_HDR_BYTES - ext_cur;

  always_comb begin
    pos_nxt  = pos_r;
    form_nxt = form_r;
    mask_nxt = mask_r;
    b0_nxt   = b0_r;
    len_nxt  = len_r;
    key_nxt  = key_r;
    if (pos_r == 4'd0) begin
      b0_nxt  = beat.data;
      pos_nxt = 4'd1;
    end else if (pos_r == 4'd1) begin
      mask_nxt = beat.data[7];
      key_nxt  = '0;
      if (code == LEN_CODE_16) begin
        form_nxt = FORM_EXT16;
        len_nxt  = '0;
      end else if (code == LEN_CODE_64) begin
        form_nxt = FORM_EXT64;
        len_nxt  = '0;
      end else begin
        form_nxt = FORM_SHORT;
        len_nxt  = {57'd0, code};
      end
      pos_nxt = 4'd2;
    end else begin
      if (pos_r < BASE_HDR_BYTES + ext_cur) begin
        len_nxt = {len_r[55:0], beat.data};
      end else if (key_idx < KEY_BYTES) begin
        // key bytes land little-end first
        case (key_idx[1:0])
          2'd0:    key_nxt[7:0]   = beat.data;
          2'd1:    key_nxt[15:8]  = beat.data;
          2'd2:    key_nxt[23:16] = beat.data;
          default: key_nxt[31:24] = beat.data;
        endcase
      end
      pos_nxt = pos_r + 4'd1;
    end
  end

  always_comb begin
    case (form_nxt)
      FORM_EXT16: ext_nxt = EXT16_BYTES;
      FORM_EXT64: ext_nxt = EXT64_BYTES;
      default:    ext_nxt = 4'd0;
    endcase
  end

  assign total = BASE_HDR_BYTES + ext_nxt + (mask_nxt ? KEY_BYTES : 4'd0);
  assign done  = pos_nxt >= total;

  always_comb begin
    res_nxt.fin            = b0_nxt[7];
    res_nxt.rsv1           = b0_nxt[6];
    res_nxt.rsv2           = b0_nxt[5];
    res_nxt.rsv3           = b0_nxt[4];
    res_nxt.opcode         = b0_nxt[3:0];
    res_nxt.mask_present   = mask_nxt;
    res_nxt.payload_length = len_nxt;
    res_nxt.mask_key       = mask_nxt ? key_nxt : 32'd0;
    res_nxt.header_length  = total;
  end

  assign res_vld_nxt = out_free ? (take && done) : res_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 4'd0;
      form_r    <= FORM_SHORT;
      mask_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (take) begin
        if (done) begin
          pos_r  <= 4'd0;
          form_r <= FORM_SHORT;
          mask_r <= 1'b0;
        end else begin
          pos_r  <= pos_nxt;
          form_r <= form_nxt;
          mask_r <= mask_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b0_r  <= b0_nxt;
      len_r <= len_nxt;
      key_r <= key_nxt;
    end
    if (take && done && out_free) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_hdr   = res_r;

  `ASSERT_CLK(a_pos_range, pos_r <= 4'd13, "byte position past longest header")
  `ASSERT_NEXT(a_done_clears, take && done, pos_r == 4'd0, "state not cleared after header")
  `ASSERT_NEXT(a_done_loads, take && done, res_vld_r, "completed header not registered")
  `ASSERT_IMPL(a_key_zero, res_vld_r && !res_r.mask_present, res_r.mask_key == 32'd0,
    "mask key set without mask flag")
  `ASSERT_IMPL(a_hdr_len, res_vld_r,
    res_r.header_length == 4'd2 || res_r.header_length == 4'd4 ||
    res_r.header_length == 4'd6 || res_r.header_length == 4'd8 ||
    res_r.header_length == 4'd10 || res_r.header_length == 4'd14,
    "impossible header length")

endmodule
